[hw/rtl/sebr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spike event bus router package
// Shared widths, codes and item types for the event router.
// ----------------------------------------------------------------------------
package sebr_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 5;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned SEL_W     = 3;
  localparam int unsigned WARN_W    = 2;

  localparam logic [DATA_W-1:0] BARRIER_ID = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] ADDR_STEP  = DATA_W'(4);
  localparam logic [IDX_W-1:0]  TZ_EMPTY   = IDX_W'(31);

  typedef enum logic [KIND_W-1:0] {
    KIND_BUS   = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [SEL_W-1:0] {
    SEL_BITFIELD  = 3'd0,
    SEL_ID_BASE   = 3'd1,
    SEL_BARRIER   = 3'd2,
    SEL_EVT_ADDR  = 3'd3,
    SEL_BAR_COUNT = 3'd4
  } reg_sel_e;

  typedef enum logic [WARN_W-1:0] {
    WARN_NONE     = 2'd0,
    WARN_BITFIELD = 2'd1,
    WARN_BARRIER  = 2'd2
  } warn_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEL_W-1:0]  register_select;
    logic [DATA_W-1:0] write_data;
    logic              bus_rx_valid;
    logic [DATA_W-1:0] bus_rx_data;
    logic              bus_granted;
  } item_t;

  typedef struct packed {
    logic              tx_valid;
    logic [DATA_W-1:0] tx_data;
    logic              mem_write_valid;
    logic [DATA_W-1:0] mem_write_address;
    logic [DATA_W-1:0] mem_write_data;
    logic [DATA_W-1:0] read_data;
    logic [WARN_W-1:0] overwrite_warning;
  } result_t;

endpackage

[hw/rtl/sebr_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Router input channel
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface sebr_in_if;
  logic                         valid;
  logic                         ready;
  logic [sebr_pkg::KIND_W-1:0]  kind;
  logic [sebr_pkg::SEL_W-1:0]   register_select;
  logic [sebr_pkg::DATA_W-1:0]  write_data;
  logic                         bus_rx_valid;
  logic [sebr_pkg::DATA_W-1:0]  bus_rx_data;
  logic                         bus_granted;

  modport source (
    output valid, kind, register_select, write_data, bus_rx_valid, bus_rx_data,
           bus_granted,
    input  ready
  );
  modport sink (
    input  valid, kind, register_select, write_data, bus_rx_valid, bus_rx_data,
           bus_granted,
    output ready
  );
endinterface

[hw/rtl/sebr_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Router output channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface sebr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         tx_valid;
  logic [sebr_pkg::DATA_W-1:0]  tx_data;
  logic                         mem_write_valid;
  logic [sebr_pkg::DATA_W-1:0]  mem_write_address;
  logic [sebr_pkg::DATA_W-1:0]  mem_write_data;
  logic [sebr_pkg::DATA_W-1:0]  read_data;
  logic [sebr_pkg::WARN_W-1:0]  overwrite_warning;

  modport source (
    output valid, tx_valid, tx_data, mem_write_valid, mem_write_address,
           mem_write_data, read_data, overwrite_warning,
    input  ready
  );
  modport sink (
    input  valid, tx_valid, tx_data, mem_write_valid, mem_write_address,
           mem_write_data, read_data, overwrite_warning,
    output ready
  );
endinterface

[hw/rtl/sebr_ctz.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trailing-zero counter
// Priority encoder giving the lowest set bit; an empty word reads as 31.
// ----------------------------------------------------------------------------
module sebr_ctz (
  input  logic [sebr_pkg::DATA_W-1:0] word_i,
  output logic [sebr_pkg::IDX_W-1:0]  count_o
);

  always_comb begin
    count_o = sebr_pkg::TZ_EMPTY;
    for (int i = sebr_pkg::DATA_W - 1; i >= 0; i--) begin
      if (word_i[i]) begin
        count_o = sebr_pkg::IDX_W'(i);
      end
    end
  end

endmodule

[hw/rtl/sebr_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Router core
// Register file, send sequencer and receive path; updates on each item.
// ----------------------------------------------------------------------------
module sebr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  sebr_pkg::item_t     item_i,
  output sebr_pkg::result_t   result_o
);

  typedef enum logic [1:0] {
    ST_IDLE         = 2'd0,
    ST_EXTRACT      = 2'd1,
    ST_WAIT_SPIKE   = 2'd2,
    ST_WAIT_BARRIER = 2'd3
  } state_e;

  localparam int unsigned DW = sebr_pkg::DATA_W;
  localparam int unsigned IW = sebr_pkg::IDX_W;

  state_e        state_q, state_d;
  logic [DW-1:0] pending_q, pending_d;
  logic [DW-1:0] base_q, base_d;
  logic [DW-1:0] barrier_q, barrier_d;
  logic [DW-1:0] addr_q, addr_d;
  logic [DW-1:0] count_q, count_d;
  logic [DW-1:0] work_q, work_d;
  logic [DW-1:0] lbase_q, lbase_d;
  logic [IW-1:0] idx_q, idx_d;

  logic [IW-1:0] tz;
  logic          is_bus;
  logic          rx_event;
  logic          rx_barrier;

  sebr_ctz u_ctz (
    .word_i  (work_q),
    .count_o (tz)
  );

  assign is_bus     = (item_i.kind == sebr_pkg::KIND_BUS);
  assign rx_barrier = is_bus && item_i.bus_rx_valid && (item_i.bus_rx_data == sebr_pkg::BARRIER_ID);
  assign rx_event   = is_bus && item_i.bus_rx_valid && (item_i.bus_rx_data != sebr_pkg::BARRIER_ID);

  always_comb begin
    state_d   = state_q;
    pending_d = pending_q;
    base_d    = base_q;
    barrier_d = barrier_q;
    addr_d    = addr_q;
    count_d   = count_q;
    work_d    = work_q;
    lbase_d   = lbase_q;
    idx_d     = idx_q;
    result_o  = '0;

    case (item_i.kind)
      sebr_pkg::KIND_BUS: begin
        if (rx_barrier) begin
          count_d = count_q + DW'(1);
        end
        if (rx_event) begin
          result_o.mem_write_valid   = 1'b1;
          result_o.mem_write_address = addr_q;
          result_o.mem_write_data    = item_i.bus_rx_data;
          addr_d                     = addr_q + sebr_pkg::ADDR_STEP;
        end
        case (state_q)
          ST_IDLE: begin
            if (pending_q != '0) begin
              work_d    = pending_q;
              lbase_d   = base_q;
              idx_d     = '0;
              state_d   = ST_EXTRACT;
              pending_d = '0;
            end else if (barrier_q != '0) begin
              state_d   = ST_WAIT_BARRIER;
              barrier_d = '0;
            end
          end
          ST_EXTRACT: begin
            idx_d   = idx_q + tz;
            work_d  = (work_q >> tz) >> 1;
            state_d = ST_WAIT_SPIKE;
          end
          ST_WAIT_SPIKE: begin
            result_o.tx_valid = 1'b1;
            result_o.tx_data  = DW'(idx_q) | lbase_q;
            if (item_i.bus_granted) begin
              if (work_q == '0) begin
                state_d = ST_IDLE;
              end else begin
                idx_d   = idx_q + IW'(1);
                state_d = ST_EXTRACT;
              end
            end
          end
          default: begin
            result_o.tx_valid = 1'b1;
            result_o.tx_data  = sebr_pkg::BARRIER_ID;
            if (item_i.bus_granted) begin
              state_d = ST_IDLE;
            end
          end
        endcase
      end
      sebr_pkg::KIND_WRITE: begin
        case (item_i.register_select)
          sebr_pkg::SEL_BITFIELD: begin
            if (pending_q != '0) begin
              result_o.overwrite_warning = sebr_pkg::WARN_BITFIELD;
            end
            pending_d = item_i.write_data;
          end
          sebr_pkg::SEL_ID_BASE:   base_d = item_i.write_data;
          sebr_pkg::SEL_BARRIER: begin
            if (barrier_q != '0) begin
              result_o.overwrite_warning = sebr_pkg::WARN_BARRIER;
            end
            barrier_d = item_i.write_data;
          end
          sebr_pkg::SEL_EVT_ADDR:  addr_d  = item_i.write_data;
          sebr_pkg::SEL_BAR_COUNT: count_d = item_i.write_data;
          default: ;
        endcase
      end
      sebr_pkg::KIND_READ: begin
        case (item_i.register_select)
          sebr_pkg::SEL_BITFIELD:  result_o.read_data = pending_q;
          sebr_pkg::SEL_ID_BASE:   result_o.read_data = base_q;
          sebr_pkg::SEL_BARRIER:   result_o.read_data = barrier_q;
          sebr_pkg::SEL_EVT_ADDR:  result_o.read_data = addr_q;
          sebr_pkg::SEL_BAR_COUNT: result_o.read_data = count_q;
          default:                 result_o.read_data = '0;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pending_q <= '0;
      base_q    <= '0;
      barrier_q <= '0;
      addr_q    <= '0;
      count_q   <= '0;
      work_q    <= '0;
      lbase_q   <= '0;
      idx_q     <= '0;
    end else if (fire_i) begin
      state_q   <= state_d;
      pending_q <= pending_d;
      base_q    <= base_d;
      barrier_q <= barrier_d;
      addr_q    <= addr_d;
      count_q   <= count_d;
      work_q    <= work_d;
      lbase_q   <= lbase_d;
      idx_q     <= idx_d;
    end
  end

endmodule

[hw/rtl/spike_event_bus_router_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spike event bus router
// Register access and bus-cycle sequencing for a shared spike event bus.
// ----------------------------------------------------------------------------
// Every input item (register write, register read or one bus cycle) yields
// exactly one result item, held in an output register and presented in the
// cycle after acceptance. A new item is accepted every clock while the output
// register is empty or being drained in the same cycle, so throughput is one
// item per cycle; the figure is set by the single output register. The
// lowest-set-bit priority encoder sits between the working bitfield and the
// spike index register, off the result path.
module spike_event_bus_router_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  sebr_in_if.sink     in_i,
  sebr_out_if.source  out_o
);

  sebr_pkg::item_t   item;
  sebr_pkg::result_t result;
  sebr_pkg::result_t res_q;
  logic              out_valid_q;
  logic              fire;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign fire       = in_i.valid && in_i.ready;

  assign item.kind            = in_i.kind;
  assign item.register_select = in_i.register_select;
  assign item.write_data      = in_i.write_data;
  assign item.bus_rx_valid    = in_i.bus_rx_valid;
  assign item.bus_rx_data     = in_i.bus_rx_data;
  assign item.bus_granted     = in_i.bus_granted;

  sebr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= result;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.tx_valid          = res_q.tx_valid;
  assign out_o.tx_data           = res_q.tx_data;
  assign out_o.mem_write_valid   = res_q.mem_write_valid;
  assign out_o.mem_write_address = res_q.mem_write_address;
  assign out_o.mem_write_data    = res_q.mem_write_data;
  assign out_o.read_data         = res_q.read_data;
  assign out_o.overwrite_warning = res_q.overwrite_warning;

endmodule
